// ===== hdl/epm_pkg.sv =====
// ----------------------------------------------------------------------------
// epm_pkg: shared types, constants and helpers for the Euler pose matrix block.
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int CORDIC_STEPS    = 24;
  localparam int QB              = 30;
  localparam int ZW              = 34;   // CORDIC z word
  localparam int XW              = 33;   // CORDIC x/y word (signed Q30 plus growth)

  localparam logic [1:0] OP_XFORM = 2'd0;
  localparam logic [1:0] OP_DA    = 2'd1;
  localparam logic [1:0] OP_DB    = 2'd2;
  localparam logic [1:0] OP_DC    = 2'd3;

  localparam logic signed [XW-1:0] CORDIC_K = 33'sd652032874;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 34'sd536870912;   1: t = 34'sd316933406;   2: t = 34'sd167458907;
      3: t = 34'sd85004756;    4: t = 34'sd42667331;    5: t = 34'sd21354465;
      6: t = 34'sd10680862;    7: t = 34'sd5340245;     8: t = 34'sd2670163;
      9: t = 34'sd1335087;     10: t = 34'sd667544;     11: t = 34'sd333772;
      12: t = 34'sd166886;     13: t = 34'sd83443;      14: t = 34'sd41721;
      15: t = 34'sd20860;      16: t = 34'sd10430;      17: t = 34'sd5215;
      18: t = 34'sd2607;       19: t = 34'sd1303;       20: t = 34'sd651;
      21: t = 34'sd325;        22: t = 34'sd162;        23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Q30 product, rounded half away from zero.
  function automatic logic signed [XW-1:0] mq(input logic signed [XW-1:0] p,
                                              input logic signed [XW-1:0] q);
    logic signed [2*XW-1:0] pr;
    logic signed [2*XW-1:0] mag;
    logic signed [2*XW-1:0] r;
    pr  = p * q;
    mag = pr[2*XW-1] ? -pr : pr;
    r   = (mag + (66'sd1 <<< (QB-1))) >>> QB;
    if (pr[2*XW-1]) r = -r;
    return r[XW-1:0];
  endfunction

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
  } epm_side_t;

endpackage

// ===== hdl/epm_cordic.sv =====
// ----------------------------------------------------------------------------
// epm_cordic: pipelined rotation-mode CORDIC, sine and cosine in Q30.
// One iteration per stage plus an input and an output stage.
// ----------------------------------------------------------------------------
module epm_cordic #(
  parameter int ANGLE_WIDTH = epm_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ANGLE_WIDTH-1:0]        angle,
  output logic signed [epm_pkg::XW-1:0] sin_q,
  output logic signed [epm_pkg::XW-1:0] cos_q
);
  import epm_pkg::*;

  logic signed [XW-1:0] x [CORDIC_STEPS+1];
  logic signed [XW-1:0] y [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z [CORDIC_STEPS+1];
  logic                 flip [CORDIC_STEPS+1];

  logic [31:0] th;
  logic [31:0] thf;
  logic        fl;

  always_comb begin
    th  = {angle, {(32-ANGLE_WIDTH){1'b0}}};
    fl  = th[31] ^ th[30];
    thf = fl ? th + 32'h8000_0000 : th;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CORDIC_K;
      y[0]    <= '0;
      z[0]    <= ZW'(signed'(thf));
      flip[0] <= fl;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_turn(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= flip[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
      cos_q <= flip[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
    end
  end

endmodule

// ===== hdl/epm_matrix.sv =====
// ----------------------------------------------------------------------------
// epm_matrix: products, op selection, rounding and saturation.
// Three register stages: pair products, triple products, sums and output.
// ----------------------------------------------------------------------------
module epm_matrix #(
  parameter int FRAC_BITS = epm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [epm_pkg::XW-1:0] sa, ca, sb, cb, sc, cc,
  input  epm_pkg::epm_side_t            side_in,
  output logic signed [15:0]            m_out [9],
  output epm_pkg::epm_side_t            side_out
);
  import epm_pkg::*;

  localparam int SH = QB - FRAC_BITS;

  // stage 1
  logic signed [XW-1:0] p, r, cacb, sacb, sa1, ca1, sb1, cb1, sc1, cc1;
  epm_side_t s1;
  // stage 2
  logic signed [XW-1:0] psc, pcc, rsc, rcc, sacc, sasc, cacc, casc;
  logic signed [XW-1:0] cbsc, cbcc, sbsc, sbcc, cacbsc, cacbcc, sacbsc, sacbcc;
  logic signed [XW-1:0] p2, r2, cacb2, sacb2, sb2, cb2;
  epm_side_t s2;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= mq(ca, sb);  r <= mq(sa, sb);
      cacb <= mq(ca, cb); sacb <= mq(sa, cb);
      sa1 <= sa; ca1 <= ca; sb1 <= sb; cb1 <= cb; sc1 <= sc; cc1 <= cc;
      s1 <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psc <= mq(p, sc1);  pcc <= mq(p, cc1);
      rsc <= mq(r, sc1);  rcc <= mq(r, cc1);
      sacc <= mq(sa1, cc1); sasc <= mq(sa1, sc1);
      cacc <= mq(ca1, cc1); casc <= mq(ca1, sc1);
      cbsc <= mq(cb1, sc1); cbcc <= mq(cb1, cc1);
      sbsc <= mq(sb1, sc1); sbcc <= mq(sb1, cc1);
      cacbsc <= mq(cacb, sc1); cacbcc <= mq(cacb, cc1);
      sacbsc <= mq(sacb, sc1); sacbcc <= mq(sacb, cc1);
      p2 <= p; r2 <= r; cacb2 <= cacb; sacb2 <= sacb; sb2 <= sb1; cb2 <= cb1;
      s2 <= s1;
    end
  end

  function automatic logic signed [15:0] to_out(input logic signed [XW+1:0] v);
    logic signed [XW+1:0] mag;
    logic signed [XW+1:0] t;
    if (SH > 0) begin
      mag = v[XW+1] ? -v : v;
      t   = (mag + ((XW+2)'(1) <<< (SH-1))) >>> SH;
      if (v[XW+1]) t = -t;
    end else begin
      t = v;
    end
    if (t > 32767) return 16'sh7fff;
    if (t < -32768) return 16'sh8000;
    return t[15:0];
  endfunction

  logic signed [XW+1:0] m [9];

  function automatic logic signed [XW+1:0] e(input logic signed [XW-1:0] v);
    return (XW+2)'(v);
  endfunction

  always_comb begin
    case (s2.op)
      OP_XFORM: begin
        m[0] = e(cacb2);          m[1] = e(psc) - e(sacc);  m[2] = e(pcc) + e(sasc);
        m[3] = e(sacb2);          m[4] = e(rsc) + e(cacc);  m[5] = e(rcc) - e(casc);
        m[6] = -e(sb2);           m[7] = e(cbsc);           m[8] = e(cbcc);
      end
      OP_DA: begin
        m[0] = -e(sacb2);         m[1] = -e(rsc) - e(cacc); m[2] = e(casc) - e(rcc);
        m[3] = e(cacb2);          m[4] = e(psc) - e(sacc);  m[5] = e(pcc) + e(sasc);
        m[6] = '0;                m[7] = '0;                m[8] = '0;
      end
      OP_DB: begin
        m[0] = -e(p2);            m[1] = e(cacbsc);         m[2] = e(cacbcc);
        m[3] = -e(r2);            m[4] = e(sacbsc);         m[5] = e(sacbcc);
        m[6] = -e(cb2);           m[7] = -e(sbsc);          m[8] = -e(sbcc);
      end
      default: begin
        m[0] = '0;                m[1] = e(pcc) + e(sasc);  m[2] = e(sacc) - e(psc);
        m[3] = '0;                m[4] = e(rcc) - e(casc);  m[5] = -e(rsc) - e(cacc);
        m[6] = '0;                m[7] = e(cbcc);           m[8] = -e(cbsc);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) m_out[k] <= to_out(m[k]);
      // Gradients carry no translation.
      side_out.op <= s2.op;
      side_out.sx <= (s2.op == OP_XFORM) ? s2.sx : '0;
      side_out.sy <= (s2.op == OP_XFORM) ? s2.sy : '0;
      side_out.sz <= (s2.op == OP_XFORM) ? s2.sz : '0;
    end
  end

endmodule

// ===== hdl/euler_pose_matrix_and_gradients.sv =====
// ----------------------------------------------------------------------------
// euler_pose_matrix_and_gradients: ZYX Euler pose matrix and its gradients.
// Usage:
//   Input channel (valid/ready) carries op, three binary angles and a
//   translation; output channel (valid/ready) carries r00..r22 and out_x/y/z.
//   Op 0 gives [R | t], ops 1..3 give dR/da, dR/db, dR/dc with zero t.
// Throughput: one pose per cycle unless the output stalls; set by the unrolled CORDIC stage chain.
// Reset clears all stage valid bits; data registers are not reset.
// Stall: the whole pipeline advances as one. While the final stage holds an
//   untaken result and the receiver holds ready low, every stage freezes,
//   bubbles included, and ready drops until the result is taken.
// ----------------------------------------------------------------------------
module euler_pose_matrix_and_gradients #(
  parameter int ANGLE_WIDTH = epm_pkg::ANGLE_WIDTH_DEF,
  parameter int FRAC_BITS   = epm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [15:0] angle_a,
  input  logic signed [15:0] angle_b,
  input  logic signed [15:0] angle_c,
  input  logic signed [23:0] shift_x,
  input  logic signed [23:0] shift_y,
  input  logic signed [23:0] shift_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z
);
  import epm_pkg::*;

  localparam int LAT = CORDIC_STEPS + 5;

  // Whole-pipe enable: advance when the output slot is free or being taken.
  logic en;
  logic [LAT-1:0] vld;
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [XW-1:0] sa, ca, sb, cb, sc, cc;

  epm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_ca (
    .clk(clk), .en(en), .angle(angle_a[ANGLE_WIDTH-1:0]), .sin_q(sa), .cos_q(ca));
  epm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cb (
    .clk(clk), .en(en), .angle(angle_b[ANGLE_WIDTH-1:0]), .sin_q(sb), .cos_q(cb));
  epm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cc (
    .clk(clk), .en(en), .angle(angle_c[ANGLE_WIDTH-1:0]), .sin_q(sc), .cos_q(cc));

  // Side data delay line matching the CORDIC depth.
  epm_side_t side [CORDIC_STEPS+2];
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{op: op, sx: shift_x, sy: shift_y, sz: shift_z};
      for (int k = 1; k < CORDIC_STEPS+2; k++) side[k] <= side[k-1];
    end
  end

  logic signed [15:0] m [9];
  epm_side_t so;

  epm_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk(clk), .en(en),
    .sa(sa), .ca(ca), .sb(sb), .cb(cb), .sc(sc), .cc(cc),
    .side_in(side[CORDIC_STEPS+1]), .m_out(m), .side_out(so));

  assign r00 = m[0]; assign r01 = m[1]; assign r02 = m[2];
  assign r10 = m[3]; assign r11 = m[4]; assign r12 = m[5];
  assign r20 = m[6]; assign r21 = m[7]; assign r22 = m[8];
  assign out_x = so.sx;
  assign out_y = so.sy;
  assign out_z = so.sz;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: check of the Euler ZYX pose matrix and gradient block.
// Drives poses with random gaps and output stalls, predicts every matrix in
// the bench with a bit-exact CORDIC and Q30 arithmetic, and compares fields.
// ----------------------------------------------------------------------------
module tb_top;
  import epm_pkg::*;

  typedef struct {
    logic signed [15:0] m [9];
    logic signed [23:0] tx, ty, tz;
  } pose_res_t;

  class pose_scoreboard;
    pose_res_t pending [$];
    int        errors;

    static function longint fshr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v - 1) >>> s) - 1;
    endfunction

    static function longint rshr(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
    endfunction

    static function longint qmul(longint p, longint q);
      return rshr(p * q, QB);
    endfunction

    static function void sin_cos(logic [15:0] ang, output longint s, output longint c);
      logic [31:0] th;
      logic        flip;
      longint      x, y, z, nx;
      longint      tab [24];
      tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10680862, 5340245, 2670163, 1335087, 667544, 333772,
              166886, 83443, 41721, 20860, 10430, 5215,
              2607, 1303, 651, 325, 162, 81};
      th = {ang, 16'h0};
      flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
      if (flip) th = th + 32'h8000_0000;
      z = longint'(signed'(th));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        if (z >= 0) begin
          nx = x - fshr(y, i); y = y + fshr(x, i); z -= tab[i];
        end else begin
          nx = x + fshr(y, i); y = y - fshr(x, i); z += tab[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      s = y;
      c = x;
    endfunction

    static function logic signed [15:0] to_q14(longint v);
      v = rshr(v, QB - 14);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_pose(logic [1:0] op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                            logic [23:0] x, logic [23:0] y, logic [23:0] z);
      longint    sa, ca, sb, cb, sc, cc, p, r, ab, sab;
      longint    m [9];
      pose_res_t e;
      sin_cos(a, sa, ca);
      sin_cos(b, sb, cb);
      sin_cos(c, sc, cc);
      p = qmul(ca, sb);
      r = qmul(sa, sb);
      case (op)
        OP_XFORM: m = '{qmul(ca, cb), qmul(p, sc) - qmul(sa, cc), qmul(p, cc) + qmul(sa, sc),
                        qmul(sa, cb), qmul(r, sc) + qmul(ca, cc), qmul(r, cc) - qmul(ca, sc),
                        -sb, qmul(cb, sc), qmul(cb, cc)};
        OP_DA: m = '{-qmul(sa, cb), -qmul(r, sc) - qmul(ca, cc), qmul(ca, sc) - qmul(r, cc),
                     qmul(ca, cb), qmul(p, sc) - qmul(sa, cc), qmul(p, cc) + qmul(sa, sc),
                     0, 0, 0};
        OP_DB: begin
          ab = qmul(ca, cb);
          sab = qmul(sa, cb);
          m = '{-p, qmul(ab, sc), qmul(ab, cc), -r, qmul(sab, sc), qmul(sab, cc),
                -cb, -qmul(sb, sc), -qmul(sb, cc)};
        end
        default: m = '{0, qmul(p, cc) + qmul(sa, sc), qmul(sa, cc) - qmul(p, sc),
                       0, qmul(r, cc) - qmul(ca, sc), -qmul(r, sc) - qmul(ca, cc),
                       0, qmul(cb, cc), -qmul(cb, sc)};
      endcase
      foreach (m[k]) e.m[k] = to_q14(m[k]);
      e.tx = (op == OP_XFORM) ? x : '0;
      e.ty = (op == OP_XFORM) ? y : '0;
      e.tz = (op == OP_XFORM) ? z : '0;
      pending = {pending, e};
    endfunction

    function void check_pose(pose_res_t got);
      pose_res_t e;
      if (pending.size() == 0) begin
        $error("result with no pose pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      foreach (e.m[k])
        if (e.m[k] !== got.m[k]) begin
          $error("r%0d%0d: expected %0d got %0d", k / 3, k % 3, e.m[k], got.m[k]);
          errors++;
        end
      if (e.tx !== got.tx) begin
        $error("out_x: expected %0d got %0d", e.tx, got.tx); errors++;
      end
      if (e.ty !== got.ty) begin
        $error("out_y: expected %0d got %0d", e.ty, got.ty); errors++;
      end
      if (e.tz !== got.tz) begin
        $error("out_z: expected %0d got %0d", e.tz, got.tz); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] op = '0;
  logic signed [15:0] angle_a = '0, angle_b = '0, angle_c = '0;
  logic signed [23:0] shift_x = '0, shift_y = '0, shift_z = '0;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [23:0] out_x, out_y, out_z;

  pose_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_rx = 0;

  always #10 clk = ~clk;

  euler_pose_matrix_and_gradients u_top (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Note the pose and check the result at each transfer.
  always @(posedge clk) begin
    pose_res_t g;
    if (!rst && in_valid && in_ready)
      sb.note_pose(op, angle_a, angle_b, angle_c, shift_x, shift_y, shift_z);
    if (!rst && out_valid && out_ready) begin
      g.m = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      g.tx = out_x; g.ty = out_y; g.tz = out_z;
      sb.check_pose(g);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so a back-to-back pose can follow directly.
  task automatic send_pose(logic [1:0] o, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                           logic [23:0] x, logic [23:0] y, logic [23:0] z, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; op <= o; angle_a <= a; angle_b <= b; angle_c <= c;
    shift_x <= x; shift_y <= y; shift_z <= z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3)) << 14;           // quadrant edges
      1: return (16'($urandom_range(0, 7)) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold while the sender keeps going.
  initial begin
    int w;
    @(negedge clk);
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_rx) out_ready <= 0;
      else begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        if (w > 0) begin
          out_ready <= 0;
          repeat (w) @(negedge clk);
        end
        out_ready <= 1;
      end
    end
  end

  initial begin
    logic [15:0] edges [6] = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'hffff};
    logic [23:0] sh [3] = '{24'h7fffff, 24'h800000, 24'h000000};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int i = 0; i < 24; i++)
      send_pose(2'(i), edges[i % 6], edges[(i + 2) % 6], edges[(i / 4) % 6],
                sh[i % 3], sh[(i + 1) % 3], {12'hfff, 12'(i)}, 0);
    for (int n = 0; n < 1830; n++) begin
      if (n == 300) begin
        hold_rx = 1;
        fork
          begin
            repeat (120) @(negedge clk);
            hold_rx = 0;
          end
        join_none
      end
      if (n == 900) begin
        // Drain: hold off the sender until every result is back.
        in_valid <= 0;
        @(negedge clk);
        while (sb.pending.size() != 0) @(negedge clk);
      end
      send_pose(2'($urandom), pick_angle(), pick_angle(), pick_angle(),
                24'($urandom), 24'($urandom), 24'($urandom),
                (n % 200 < 60) ? 0 : $urandom_range(0, 14));
    end
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
